[sv/grid_path_backtrack_search_defines.svh]
// assertion macros for the maze path search block
`ifndef GRID_PATH_BACKTRACK_SEARCH_DEFINES_SVH
`define GRID_PATH_BACKTRACK_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GPBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gpbs assertion failed");
// next-cycle implication
`define GPBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gpbs assertion failed");
`else
`define GPBS_ASSERT_NOW(lbl, ante, cons)
`define GPBS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[sv/gpbs_pkg.sv]
`timescale 1ns / 1ps

package gpbs_pkg;

  localparam int GRID_SIZE = 8;
  localparam int MAX_CELLS = 8;
  localparam int EFF_SIZE  = (GRID_SIZE > MAX_CELLS) ? MAX_CELLS : GRID_SIZE;
  localparam int STACK_CAP = 15;

  localparam int ROW_W   = 3;
  localparam int CELL_W  = 8;
  localparam int DEPTH_W = 4;

  localparam logic [ROW_W-1:0]  GOAL_POS = ROW_W'(EFF_SIZE - 1);
  localparam logic [ROW_W:0]    EFF_LIM  = (ROW_W + 1)'(EFF_SIZE);
  localparam logic [CELL_W-1:0] COL_MASK = CELL_W'((1 << EFF_SIZE) - 1);
  localparam logic [DEPTH_W-1:0] STACK_LIM = DEPTH_W'(STACK_CAP);

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_SOLVE = 1'b1;

  localparam logic MOVE_ROW = 1'b0;
  localparam logic MOVE_COL = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [ROW_W-1:0]  row_index;
    logic [CELL_W-1:0] open_cells;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [ROW_W-1:0]  out_row;
    logic [CELL_W-1:0] path_cells;
    logic              last_row;
  } out_item_t;

  typedef struct packed {
    logic             en;
    logic             set;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
  } mark_req_t;

  typedef struct packed {
    logic done;
    logic found;
  } walk_status_t;

endpackage

[sv/grid_path_backtrack_search.sv]
// maze path search by depth-first backtracking
// input channel (in_valid_i / in_stall_o / in_data_i): a transaction with kind 0
//   writes one maze row (bit j open = column j open), giving no result;
//   kind 1 starts a search from the top-left to the bottom-right cell,
//   moving down first, then right
// output channel (out_valid_o / out_stall_i / out_data_o): after each search the
//   block reports one transaction per grid row, rows 0 to 7 in order, each with
//   the found flag, the row index, its path mask and last_row on the final row
// a search first checks the start and goal cells, then tries each move or step
//   of backtrack in turn through the shared neighbor check unit, then hands over
//   to the path report, which advances only while the output register is free
// in_stall_o is high from the search start until the last row has entered the
//   output register; row loads stream at one per cycle while in_stall_o is low
// out_stall_i holds the output register and its payload; the report waits
// reset clears the maze (all cells blocked), the path store and the sequencers
`timescale 1ns / 1ps
`include "grid_path_backtrack_search_defines.svh"

module grid_path_backtrack_search (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gpbs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gpbs_pkg::out_item_t out_data_o
);
  import gpbs_pkg::*;

  typedef enum logic [2:0] {
    T_IDLE   = 3'b001,
    T_SOLVE  = 3'b010,
    T_REPORT = 3'b100
  } top_state_e;

  localparam logic [ROW_W-1:0] LAST_ROW_IDX = ROW_W'(EFF_SIZE - 1);

  top_state_e       state_q, state_d;
  logic             found_q, found_d;
  logic [ROW_W-1:0] rep_q, rep_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic              in_acc;
  logic              ld_en;
  logic              start;
  logic              out_free;
  logic [ROW_W-1:0]  rd_row;
  logic [CELL_W-1:0] rd_cells;
  logic              start_open;
  logic              goal_open;
  logic [CELL_W-1:0] rep_cells;
  mark_req_t         mark;
  walk_status_t      status;

  assign in_stall_o = (state_q != T_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ld_en      = in_acc && (in_data_i.kind == KIND_LOAD);
  assign start      = in_acc && (in_data_i.kind == KIND_SOLVE);
  assign out_free   = !out_valid_q || !out_stall_i;

  gpbs_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_en_i     (ld_en),
    .ld_row_i    (in_data_i.row_index),
    .ld_cells_i  (in_data_i.open_cells),
    .clr_i       (start),
    .mark_i      (mark),
    .rd_row_i    (rd_row),
    .rd_cells_o  (rd_cells),
    .start_open_o(start_open),
    .goal_open_o (goal_open),
    .rep_row_i   (rep_q),
    .rep_cells_o (rep_cells)
  );

  gpbs_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .start_open_i(start_open),
    .goal_open_i (goal_open),
    .rd_row_o    (rd_row),
    .rd_cells_i  (rd_cells),
    .mark_o      (mark),
    .status_o    (status)
  );

  always_comb begin
    state_d     = state_q;
    found_d     = found_q;
    rep_d       = rep_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      T_IDLE: begin
        if (start) begin
          state_d = T_SOLVE;
        end
      end
      T_SOLVE: begin
        if (status.done) begin
          found_d = status.found;
          rep_d   = '0;
          state_d = T_REPORT;
        end
      end
      T_REPORT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{found: found_q, out_row: rep_q, path_cells: rep_cells,
                    last_row: (rep_q == LAST_ROW_IDX)};
          rep_d = rep_q + ROW_W'(1);
          if (rep_q == LAST_ROW_IDX) begin
            state_d = T_IDLE;
          end
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      found_q     <= 1'b0;
      rep_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      found_q     <= found_d;
      rep_q       <= rep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `GPBS_ASSERT_NOW(a_done_in_solve, status.done, state_q == T_SOLVE)
  `GPBS_ASSERT_NOW(a_no_path_empty, out_valid_o && !out_data_o.found, out_data_o.path_cells == '0)
  `GPBS_ASSERT_NOW(a_last_flag, out_valid_o && out_data_o.last_row, out_data_o.out_row == LAST_ROW_IDX)

endmodule

[sv/gpbs_store.sv]
`timescale 1ns / 1ps

module gpbs_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      ld_en_i,
  input  logic [gpbs_pkg::ROW_W-1:0]  ld_row_i,
  input  logic [gpbs_pkg::CELL_W-1:0] ld_cells_i,
  input  logic                      clr_i,
  input  gpbs_pkg::mark_req_t       mark_i,
  input  logic [gpbs_pkg::ROW_W-1:0]  rd_row_i,
  output logic [gpbs_pkg::CELL_W-1:0] rd_cells_o,
  output logic                      start_open_o,
  output logic                      goal_open_o,
  input  logic [gpbs_pkg::ROW_W-1:0]  rep_row_i,
  output logic [gpbs_pkg::CELL_W-1:0] rep_cells_o
);
  import gpbs_pkg::*;

  logic [MAX_CELLS-1:0][CELL_W-1:0] maze_q, maze_d;
  logic [MAX_CELLS-1:0][CELL_W-1:0] path_q, path_d;

  always_comb begin
    maze_d = maze_q;
    if (ld_en_i && ({1'b0, ld_row_i} < EFF_LIM)) begin
      maze_d[ld_row_i] = ld_cells_i & COL_MASK;
    end
  end

  always_comb begin
    path_d = path_q;
    if (clr_i) begin
      path_d = '0;
    end else if (mark_i.en) begin
      path_d[mark_i.row][mark_i.col] = mark_i.set;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maze_q <= '0;
      path_q <= '0;
    end else begin
      maze_q <= maze_d;
      path_q <= path_d;
    end
  end

  assign rd_cells_o   = maze_q[rd_row_i];
  assign start_open_o = maze_q[0][0];
  assign goal_open_o  = maze_q[GOAL_POS][GOAL_POS];
  assign rep_cells_o  = path_q[rep_row_i];

endmodule

[sv/gpbs_walker.sv]
`timescale 1ns / 1ps
`include "grid_path_backtrack_search_defines.svh"

module gpbs_walker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        start_open_i,
  input  logic                        goal_open_i,
  output logic [gpbs_pkg::ROW_W-1:0]  rd_row_o,
  input  logic [gpbs_pkg::CELL_W-1:0] rd_cells_i,
  output gpbs_pkg::mark_req_t         mark_o,
  output gpbs_pkg::walk_status_t      status_o
);
  import gpbs_pkg::*;

  typedef enum logic [4:0] {
    W_IDLE    = 5'b00001,
    W_START   = 5'b00010,
    W_TRY_ROW = 5'b00100,
    W_TRY_COL = 5'b01000,
    W_BACK    = 5'b10000
  } walk_state_e;

  walk_state_e          state_q, state_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [ROW_W-1:0]     col_q, col_d;
  logic [DEPTH_W-1:0]   depth_q, depth_d;
  logic [STACK_CAP-1:0] stack_q, stack_d;
  logic                 done_q, done_d;
  logic                 found_q, found_d;

  logic [ROW_W:0]     row_nxt;
  logic [ROW_W:0]     col_nxt;
  logic [DEPTH_W-1:0] depth_dec;
  logic               room;
  logic               down_ok;
  logic               right_ok;
  logic               at_goal;

  assign row_nxt   = {1'b0, row_q} + (ROW_W + 1)'(1);
  assign col_nxt   = {1'b0, col_q} + (ROW_W + 1)'(1);
  assign depth_dec = depth_q - DEPTH_W'(1);
  assign room      = depth_q < STACK_LIM;
  assign at_goal   = (row_q == GOAL_POS) && (col_q == GOAL_POS);

  // one maze row read a cycle: the row below while trying down, else the current row
  assign rd_row_o = (state_q == W_TRY_ROW) ? row_nxt[ROW_W-1:0] : row_q;
  assign down_ok  = (row_nxt < EFF_LIM) && rd_cells_i[col_q] && room;
  assign right_ok = (col_nxt < EFF_LIM) && rd_cells_i[col_nxt[ROW_W-1:0]] && room;

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    depth_d = depth_q;
    stack_d = stack_q;
    done_d  = 1'b0;
    found_d = found_q;
    mark_o  = '0;
    unique case (state_q)
      W_IDLE: begin
        if (start_i) begin
          row_d   = '0;
          col_d   = '0;
          depth_d = '0;
          state_d = W_START;
        end
      end
      W_START: begin
        if (start_open_i && goal_open_i) begin
          mark_o  = '{en: 1'b1, set: 1'b1, row: '0, col: '0};
          state_d = W_TRY_ROW;
        end else begin
          done_d  = 1'b1;
          found_d = 1'b0;
          state_d = W_IDLE;
        end
      end
      W_TRY_ROW: begin
        if (at_goal) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          state_d = W_IDLE;
        end else if (down_ok) begin
          stack_d[depth_q] = MOVE_ROW;
          depth_d = depth_q + DEPTH_W'(1);
          row_d   = row_nxt[ROW_W-1:0];
          mark_o  = '{en: 1'b1, set: 1'b1, row: row_nxt[ROW_W-1:0], col: col_q};
        end else begin
          state_d = W_TRY_COL;
        end
      end
      W_TRY_COL: begin
        if (right_ok) begin
          stack_d[depth_q] = MOVE_COL;
          depth_d = depth_q + DEPTH_W'(1);
          col_d   = col_nxt[ROW_W-1:0];
          mark_o  = '{en: 1'b1, set: 1'b1, row: row_q, col: col_nxt[ROW_W-1:0]};
          state_d = W_TRY_ROW;
        end else begin
          state_d = W_BACK;
        end
      end
      W_BACK: begin
        mark_o = '{en: 1'b1, set: 1'b0, row: row_q, col: col_q};
        if (depth_q == '0) begin
          done_d  = 1'b1;
          found_d = 1'b0;
          state_d = W_IDLE;
        end else begin
          depth_d = depth_dec;
          if (stack_q[depth_dec] == MOVE_ROW) begin
            row_d   = row_q - ROW_W'(1);
            state_d = W_TRY_COL;
          end else begin
            col_d   = col_q - ROW_W'(1);
          end
        end
      end
      default: begin
        state_d = W_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      depth_q <= '0;
      stack_q <= '0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      depth_q <= depth_d;
      stack_q <= stack_d;
      done_q  <= done_d;
      found_q <= found_d;
    end
  end

  assign status_o = '{done: done_q, found: found_q};

  // the search only moves down or right, so depth equals distance from the start
  `GPBS_ASSERT_NOW(a_depth_is_distance, 1'b1, depth_q == ({1'b0, row_q} + {1'b0, col_q}))
  `GPBS_ASSERT_NOW(a_pos_in_grid, 1'b1, (row_q <= GOAL_POS) && (col_q <= GOAL_POS))
  `GPBS_ASSERT_NEXT(a_done_pulse, done_q, !done_q)
  `GPBS_ASSERT_NOW(a_found_at_goal, done_q && found_q, at_goal)

endmodule
